### sv/idms_pkg.sv
// Shared types, constants and operation codes for the divide/modulo/shift unit.
package idms_pkg;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned SHAMT_W = 32;
    localparam int unsigned FUNC_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_UDIV = 3'd0,
        FN_SDIV = 3'd1,
        FN_UMOD = 3'd2,
        FN_SMOD = 3'd3,
        FN_SHL  = 3'd4,
        FN_SHRL = 3'd5,
        FN_SHRA = 3'd6,
        FN_NONE = 3'd7
    } t_func;

    // Context that travels with each transaction through the cell row.
    typedef struct packed {
        logic            valid;
        logic            rem_sel;  // deliver remainder, not quotient
        logic            neg_q;    // negate quotient at the end
        logic            neg_r;    // negate remainder at the end
        logic            bypass;   // result already known (shift, zero divisor, no-op)
        logic [DATA_W-1:0] bypass_val;
    } t_ctl;
endpackage

### sv/idms_cell.sv
// One restoring-division cell: retires one quotient bit per cycle.
module idms_cell #(
    parameter int unsigned W = idms_pkg::DATA_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idms_pkg::t_ctl       i_ctl,
    input  logic [W-1:0]         i_rem,
    input  logic [W-1:0]         i_quo,
    input  logic [W-1:0]         i_div,
    output idms_pkg::t_ctl       o_ctl,
    output logic [W-1:0]         o_rem,
    output logic [W-1:0]         o_quo,
    output logic [W-1:0]         o_div
);
    import idms_pkg::*;

    logic [W:0]   w_trial;
    logic [W:0]   w_diff;
    logic         w_ge;
    t_ctl         r_ctl;
    logic [W-1:0] r_rem, r_quo, r_div;

    // Shift in the next dividend bit, then trial-subtract.
    assign w_trial = {i_rem, i_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, i_div};
    assign w_ge    = !w_diff[W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_ctl.valid;
        end
        r_ctl.rem_sel    <= i_ctl.rem_sel;
        r_ctl.neg_q      <= i_ctl.neg_q;
        r_ctl.neg_r      <= i_ctl.neg_r;
        r_ctl.bypass     <= i_ctl.bypass;
        r_ctl.bypass_val <= i_ctl.bypass_val;
        r_rem <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
        r_quo <= {i_quo[W-2:0], w_ge};
        r_div <= i_div;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_div = r_div;
endmodule

### sv/idms_front.sv
// Input register stage: decodes the operation, takes magnitudes, does shifts.
module idms_front #(
    parameter int unsigned W = idms_pkg::DATA_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [idms_pkg::FUNC_W-1:0] i_func,
    input  logic [W-1:0]               i_a,
    input  logic [W-1:0]               i_b,
    input  logic [idms_pkg::SHAMT_W-1:0] i_shamt,
    output idms_pkg::t_ctl             o_ctl,
    output logic [W-1:0]               o_mag_a,
    output logic [W-1:0]               o_mag_b
);
    import idms_pkg::*;

    localparam int unsigned SH_W = $clog2(W);

    logic         w_signed, w_big;
    logic [W-1:0] w_mag_a, w_mag_b, w_shift;
    logic [SH_W-1:0] w_sh;
    t_ctl         n_ctl, r_ctl;
    logic [W-1:0] r_mag_a, r_mag_b;

    assign w_signed = (i_func == FN_SDIV) || (i_func == FN_SMOD);
    assign w_mag_a  = (w_signed && i_a[W-1]) ? (~i_a + 1'b1) : i_a;
    assign w_mag_b  = (w_signed && i_b[W-1]) ? (~i_b + 1'b1) : i_b;
    assign w_big    = (i_shamt >= SHAMT_W'(W));
    assign w_sh     = i_shamt[SH_W-1:0];

    always_comb begin
        case (t_func'(i_func))
            FN_SHL:  w_shift = w_big ? '0 : (i_a << w_sh);
            FN_SHRL: w_shift = w_big ? '0 : (i_a >> w_sh);
            FN_SHRA: w_shift = w_big ? {W{i_a[W-1]}} : W'($signed(i_a) >>> w_sh);
            default: w_shift = '0;
        endcase
    end

    always_comb begin
        n_ctl.valid   = i_valid;
        n_ctl.rem_sel = (i_func == FN_UMOD) || (i_func == FN_SMOD);
        n_ctl.neg_q   = w_signed && (i_a[W-1] ^ i_b[W-1]);
        n_ctl.neg_r   = w_signed && i_a[W-1];
        n_ctl.bypass  = (i_func[2] == 1'b1) || (i_b == '0);
        if (i_func[2] == 1'b1) begin
            n_ctl.bypass_val = w_shift;
        end else if (n_ctl.rem_sel) begin
            n_ctl.bypass_val = i_a;
        end else begin
            n_ctl.bypass_val = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.rem_sel    <= n_ctl.rem_sel;
        r_ctl.neg_q      <= n_ctl.neg_q;
        r_ctl.neg_r      <= n_ctl.neg_r;
        r_ctl.bypass     <= n_ctl.bypass;
        r_ctl.bypass_val <= n_ctl.bypass_val;
        r_mag_a <= w_mag_a;
        r_mag_b <= w_mag_b;
    end

    assign o_ctl   = r_ctl;
    assign o_mag_a = r_mag_a;
    assign o_mag_b = r_mag_b;
endmodule

### sv/int64_divide_modulo_shift_unit.sv
// Top level of the 64-bit divide, modulo and shift unit.
// Usage:
//   Drive i_func, i_operand_a, i_operand_b, i_shift_amount and raise start.
//   A transaction is accepted at each rising edge with start high and busy low.
//   busy is tied low: the unit takes a new transaction every cycle.
//   Each transaction yields one result on o_result, marked by o_done for
//   exactly one cycle, in issue order. The receiver cannot stall.
// Pipeline: every operation takes the same path, and shifts ride the pipe
//   alongside divisions: one input register stage, a row of W division cells
//   each retiring one quotient bit, and an output stage that applies the sign
//   fix-up.
// Throughput: one transaction per cycle.
// Division by zero yields quotient 0 and remainder equal to the dividend.
// The signed minimum divided by -1 falls out of the magnitude path: the
//   quotient magnitude 2^63 already has the minimum's bit pattern, remainder 0.
// Reset (synchronous, active low) drops all in-flight transactions;
//   data registers are not cleared.
module int64_divide_modulo_shift_unit #(
    parameter int unsigned W = idms_pkg::DATA_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [idms_pkg::FUNC_W-1:0]   i_func,
    input  logic [W-1:0]                  i_operand_a,
    input  logic [W-1:0]                  i_operand_b,
    input  logic [idms_pkg::SHAMT_W-1:0]  i_shift_amount,
    output logic                          o_done,
    output logic [W-1:0]                  o_result
);
    import idms_pkg::*;

    t_ctl         s_ctl [W+1];
    logic [W-1:0] s_rem [W+1];
    logic [W-1:0] s_quo [W+1];
    logic [W-1:0] s_div [W+1];
    logic [W-1:0] w_val;
    logic         r_done;
    logic [W-1:0] r_result;

    assign busy = 1'b0;

    idms_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_func  (i_func),
        .i_a     (i_operand_a),
        .i_b     (i_operand_b),
        .i_shamt (i_shift_amount),
        .o_ctl   (s_ctl[0]),
        .o_mag_a (s_quo[0]),
        .o_mag_b (s_div[0])
    );
    // The partial remainder starts at zero; dividend bits shift in from s_quo.
    assign s_rem[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_cell
        idms_cell #(.W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[g]),
            .i_rem   (s_rem[g]),
            .i_quo   (s_quo[g]),
            .i_div   (s_div[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_rem   (s_rem[g+1]),
            .o_quo   (s_quo[g+1]),
            .o_div   (s_div[g+1])
        );
    end

    // Pick the bypass value, quotient or remainder, and restore the sign.
    always_comb begin
        if (s_ctl[W].bypass) begin
            w_val = s_ctl[W].bypass_val;
        end else if (s_ctl[W].rem_sel) begin
            w_val = s_ctl[W].neg_r ? (~s_rem[W] + 1'b1) : s_rem[W];
        end else begin
            w_val = s_ctl[W].neg_q ? (~s_quo[W] + 1'b1) : s_quo[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= s_ctl[W].valid;
        end
        r_result <= w_val;
    end

    assign o_done   = r_done;
    assign o_result = r_result;
endmodule

### sv/idms_checker.sv
// Port-level checker for the divide/modulo/shift unit, bound to the top level.
module idms_checker #(
    parameter int unsigned W = idms_pkg::DATA_W
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         start,
    input logic         busy,
    input logic         o_done,
    input logic [W-1:0] o_result
);
    localparam int unsigned LAT = W + 2;

    a_busy_low: assert property (@(posedge i_clk) busy == 1'b0)
        else $error("busy raised");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT (o_done || !$past(i_rst_n, LAT - 1)))
        else $error("transaction lost");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without transaction");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("done after reset");

    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !$isunknown(o_result))
        else $error("result unknown");
endmodule

bind int64_divide_modulo_shift_unit idms_checker #(.W(W)) u_idms_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
